// ===== sv/bcpr_pkg.sv =====
// shared types, constants and the corner pattern test for binary corner pixel removal
package bcpr_pkg;

    localparam int PIX_W  = 8;
    localparam int CFG_W  = 11;
    localparam int IDX_W  = 1;

    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 11'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 11'd480;

    localparam logic [PIX_W-1:0] PIX_ZERO = 8'd0;
    localparam logic [PIX_W-1:0] PIX_ONE  = 8'd1;

    localparam int OUT_FIFO_DEPTH = 4;
    localparam int OUT_PTR_W      = $clog2(OUT_FIFO_DEPTH);
    localparam int OUT_LVL_W      = $clog2(OUT_FIFO_DEPTH + 1);

    typedef struct packed {
        logic             last;
        logic [PIX_W-1:0] pixel;
    } out_beat_t;

    function automatic logic corner_hit(
        input logic [PIX_W-1:0] c,
        input logic [PIX_W-1:0] n,
        input logic [PIX_W-1:0] ne,
        input logic [PIX_W-1:0] e,
        input logic [PIX_W-1:0] se,
        input logic [PIX_W-1:0] s,
        input logic [PIX_W-1:0] sw,
        input logic [PIX_W-1:0] w,
        input logic [PIX_W-1:0] nw
    );
        logic p1;
        logic p2;
        logic p3;
        logic p4;
        p1 = (n == PIX_ZERO) && (e == PIX_ZERO) && (ne == PIX_ONE) && (w == PIX_ONE);
        p2 = (n == PIX_ZERO) && (e == PIX_ONE) && (ne == PIX_ONE) && (se == PIX_ZERO);
        p3 = (s == PIX_ZERO) && (e == PIX_ONE) && (se == PIX_ONE) && (sw == PIX_ZERO);
        p4 = (s == PIX_ZERO) && (w == PIX_ONE) && (sw == PIX_ONE) && (nw == PIX_ZERO);
        return (c == PIX_ONE) && (p1 || p2 || p3 || p4);
    endfunction

endpackage

// ===== sv/binary_corner_pixel_removal.sv =====
// top level of the binary corner pixel removal stream filter
//
// pixels enter in raster order on the s_axis channel, one beat per pixel;
// s_axis_tuser set marks a drain beat that pushes out one held pixel with no
// new input. results leave on m_axis, tlast set on the final pixel of a frame.
// a result is the pixel one row plus one pixel earlier; border pixels and
// values other than 0 and 1 pass unchanged, a 1 matching a corner pattern
// is cleared.
// frame_width and frame_height are written through cfg_we / cfg_index /
// cfg_data; the user must do so only while the block is idle, which the
// block does not enforce. a write restarts the frame.
// one beat per cycle sustained while s_axis_tready stays high. a beat that
// yields a result sets b_emit_reg as its line ram read is registered; the
// window stage then pushes the result into the output queue, whose level
// register raises m_axis_tvalid. the two line rows share one ram word per
// column; a read in the same cycle as a write to that column is bypassed.
// when m_axis stalls, results collect in a four-beat queue; s_axis_tready
// drops while the queue level plus a window stage result exceeds two.
// reset clears positions, window and queue; line ram content stays undefined.
module binary_corner_pixel_removal
    import bcpr_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [PIX_W-1:0] s_axis_tdata,   // [7:0] pixel_in
    input  logic             s_axis_tuser,   // [0] func
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [PIX_W-1:0] m_axis_tdata,   // [7:0] pixel_out
    output logic             m_axis_tlast,
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int CW  = $clog2(MAX_WIDTH + 1);
    localparam int RAW = $clog2(MAX_HEIGHT);
    localparam int RW  = $clog2(MAX_HEIGHT + 1);
    localparam int HW  = $clog2(MAX_WIDTH + 2);
    localparam int MW  = 2 * PIX_W;

    logic [CFG_W-1:0]          frame_width_reg;
    logic [CFG_W-1:0]          frame_height_reg;
    logic [CW-1:0]             w_eff;
    logic [RW-1:0]             h_eff;
    logic [HW-1:0]             lag;

    logic [AW-1:0]             in_col_reg;
    logic [AW-1:0]             in_col_next;
    logic [HW-1:0]             held_reg;
    logic [HW-1:0]             held_next;

    logic                      accept;
    logic                      shift_a;
    logic                      emit_a;

    logic                      b_valid_reg;
    logic                      b_emit_reg;
    logic                      fwd_reg;
    logic                      fwd_next;
    logic [PIX_W-1:0]          b_px_reg;
    logic [AW-1:0]             b_addr_reg;
    logic [MW-1:0]             fwd_data_reg;

    logic [MW-1:0]             ram_rdata;
    logic [MW-1:0]             line_word;
    logic [MW-1:0]             wr_word;
    logic [PIX_W-1:0]          up_rd;
    logic [PIX_W-1:0]          mid_rd;

    logic [2:0][2:0][PIX_W-1:0] win_reg;
    logic [2:0][2:0][PIX_W-1:0] win_next;

    logic [AW-1:0]             out_col_reg;
    logic [AW-1:0]             out_col_next;
    logic [RAW-1:0]            out_row_reg;
    logic [RAW-1:0]            out_row_next;
    logic                      col_last;
    logic                      row_last;
    logic                      interior;
    logic                      hit;
    out_beat_t                 res_beat;
    out_beat_t                 head_beat;
    logic [OUT_LVL_W-1:0]      fifo_level;

    // effective frame size
    always_comb
    begin
        if (frame_width_reg == '0)
        begin
            w_eff = CW'(1);
        end
        else if (32'(frame_width_reg) > 32'(MAX_WIDTH))
        begin
            w_eff = CW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = CW'(frame_width_reg);
        end

        if (frame_height_reg == '0)
        begin
            h_eff = RW'(1);
        end
        else if (32'(frame_height_reg) > 32'(MAX_HEIGHT))
        begin
            h_eff = RW'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = RW'(frame_height_reg);
        end

        lag = HW'(w_eff) + HW'(1);
    end

    // input stage: accept, column count, read issue
    assign s_axis_tready = (OUT_LVL_W'(fifo_level) + OUT_LVL_W'(b_emit_reg))
                           <= OUT_LVL_W'(OUT_FIFO_DEPTH - 2);
    assign accept  = s_axis_tvalid & s_axis_tready;
    assign shift_a = accept & (!s_axis_tuser | (held_reg != '0));
    assign emit_a  = accept & (s_axis_tuser ? (held_reg != '0) : (held_reg == lag));

    always_comb
    begin
        held_next = held_reg;
        if (accept && !s_axis_tuser && (held_reg < lag))
        begin
            held_next = held_reg + HW'(1);
        end
        else if (accept && s_axis_tuser && (held_reg != '0))
        begin
            held_next = held_reg - HW'(1);
        end

        in_col_next = in_col_reg;
        if (shift_a)
        begin
            if ((CW'(in_col_reg) + CW'(1)) == w_eff)
            begin
                in_col_next = '0;
            end
            else
            begin
                in_col_next = in_col_reg + AW'(1);
            end
        end
    end

    assign fwd_next = shift_a & b_valid_reg & (b_addr_reg == in_col_reg);

    // line ram word: [15:8] middle row, [7:0] upper row
    bcpr_ram #(
        .WIDTH (MW),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (b_valid_reg),
        .waddr (b_addr_reg),
        .wdata (wr_word),
        .raddr (in_col_reg),
        .rdata (ram_rdata)
    );

    // window stage
    assign line_word = fwd_reg ? fwd_data_reg : ram_rdata;
    assign up_rd     = line_word[PIX_W-1:0];
    assign mid_rd    = line_word[MW-1:PIX_W];
    assign wr_word   = {b_px_reg, mid_rd};

    always_comb
    begin
        win_next = win_reg;
        for (int r = 0; r < 3; r++)
        begin
            win_next[r][0] = win_reg[r][1];
            win_next[r][1] = win_reg[r][2];
        end
        win_next[0][2] = up_rd;
        win_next[1][2] = mid_rd;
        win_next[2][2] = b_px_reg;
    end

    assign col_last = ((CW'(out_col_reg) + CW'(1)) == w_eff);
    assign row_last = ((RW'(out_row_reg) + RW'(1)) == h_eff);
    assign interior = (out_row_reg != '0) && ((RW'(out_row_reg) + RW'(1)) < h_eff)
                      && (out_col_reg != '0) && ((CW'(out_col_reg) + CW'(1)) < w_eff);

    assign hit = interior && corner_hit(win_next[1][1], win_next[0][1], win_next[0][2],
                                        win_next[1][2], win_next[2][2], win_next[2][1],
                                        win_next[2][0], win_next[1][0], win_next[0][0]);

    always_comb
    begin
        res_beat.pixel = hit ? PIX_ZERO : win_next[1][1];
        res_beat.last  = row_last & col_last;

        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (b_emit_reg)
        begin
            if (col_last)
            begin
                out_col_next = '0;
                out_row_next = row_last ? '0 : out_row_reg + RAW'(1);
            end
            else
            begin
                out_col_next = out_col_reg + AW'(1);
            end
        end
    end

    bcpr_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (b_emit_reg),
        .push_beat (res_beat),
        .tready    (m_axis_tready),
        .tvalid    (m_axis_tvalid),
        .head_beat (head_beat),
        .level     (fifo_level)
    );

    assign m_axis_tdata = head_beat.pixel;
    assign m_axis_tlast = head_beat.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
            in_col_reg       <= '0;
            held_reg         <= '0;
            b_valid_reg      <= 1'b0;
            b_emit_reg       <= 1'b0;
            fwd_reg          <= 1'b0;
            win_reg          <= '0;
            out_col_reg      <= '0;
            out_row_reg      <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default:          ;
            endcase
            in_col_reg  <= '0;
            held_reg    <= '0;
            b_valid_reg <= 1'b0;
            b_emit_reg  <= 1'b0;
            fwd_reg     <= 1'b0;
            win_reg     <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else
        begin
            in_col_reg  <= in_col_next;
            held_reg    <= held_next;
            b_valid_reg <= shift_a;
            b_emit_reg  <= emit_a;
            fwd_reg     <= fwd_next;
            if (b_valid_reg)
            begin
                win_reg <= win_next;
            end
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift_a)
        begin
            b_px_reg     <= s_axis_tuser ? PIX_ZERO : s_axis_tdata;
            b_addr_reg   <= in_col_reg;
            fwd_data_reg <= wr_word;
        end
    end

    // a result only comes from a beat that also moved the window
    assert property (@(posedge clk) disable iff (!rst_n)
        b_emit_reg |-> b_valid_reg)
        else $error("result without window shift");

    // a drain beat with nothing held leaves the window stage empty
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_axis_tuser && (held_reg == '0) && !cfg_we) |=> !b_valid_reg)
        else $error("empty drain moved the window");

    // the output queue always has room for the window stage result
    assert property (@(posedge clk) disable iff (!rst_n)
        b_emit_reg |-> (fifo_level < OUT_LVL_W'(OUT_FIFO_DEPTH)))
        else $error("output queue overflow");

    // bypass only follows a line ram write to the same column
    assert property (@(posedge clk) disable iff (!rst_n)
        fwd_reg |-> ($past(b_valid_reg) && b_valid_reg))
        else $error("bypass without preceding write");

endmodule

// ===== sv/bcpr_ram.sv =====
// generic simple dual-port ram with registered read
module bcpr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/bcpr_out_fifo.sv =====
// small output queue that decouples the result stage from the downstream ready
module bcpr_out_fifo
    import bcpr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  out_beat_t            push_beat,
    input  logic                 tready,
    output logic                 tvalid,
    output out_beat_t            head_beat,
    output logic [OUT_LVL_W-1:0] level
);

    out_beat_t              store_reg [OUT_FIFO_DEPTH];
    logic [OUT_PTR_W-1:0]   wr_ptr_reg;
    logic [OUT_PTR_W-1:0]   wr_ptr_next;
    logic [OUT_PTR_W-1:0]   rd_ptr_reg;
    logic [OUT_PTR_W-1:0]   rd_ptr_next;
    logic [OUT_LVL_W-1:0]   level_reg;
    logic [OUT_LVL_W-1:0]   level_next;
    logic                   pop;

    assign tvalid    = (level_reg != '0);
    assign pop       = tvalid & tready;
    assign head_beat = store_reg[rd_ptr_reg];
    assign level     = level_reg;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + OUT_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + OUT_PTR_W'(1) : rd_ptr_reg;
        level_next  = level_reg + OUT_LVL_W'(push) - OUT_LVL_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_beat;
        end
    end

endmodule

// ===== bench/corner_removal_checker.sv =====
// checker for binary corner pixel removal: predicts every output beat and compares it
module corner_removal_checker
    import bcpr_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    input  logic             s_axis_tready,
    input  logic [PIX_W-1:0] s_axis_tdata,   // [7:0] pixel_in
    input  logic             s_axis_tuser,   // [0] func
    input  logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    input  logic [PIX_W-1:0] m_axis_tdata,   // [7:0] pixel_out
    input  logic             m_axis_tlast,
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    output int               error_count,
    output int               pending_beats,
    output int               result_count,
    output int               cleared_count
);

    logic [PIX_W-1:0] row_upper [MAX_WIDTH];
    logic [PIX_W-1:0] row_middle [MAX_WIDTH];
    logic [PIX_W-1:0] win [3][3];
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    int unsigned      in_col;
    int unsigned      out_row;
    int unsigned      out_col;
    int unsigned      held;
    out_beat_t        expected_pixels [$];

    function automatic int unsigned clamp_size(input logic [CFG_W-1:0] code,
                                               input int unsigned top);
        if (code == '0)
            return 1;
        if (code > top)
            return top;
        return code;
    endfunction

    function automatic void restart_frame();
        foreach (win[r, c])
            win[r][c] = PIX_ZERO;
        in_col  = 0;
        out_row = 0;
        out_col = 0;
        held    = 0;
    endfunction

    function automatic void shift_window(input logic [PIX_W-1:0] px, input int unsigned w);
        int unsigned x;
        int r;
        x = (in_col < w) ? in_col : 0;
        for (r = 0; r < 3; r++)
        begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
        end
        win[0][2]     = row_upper[x];
        win[1][2]     = row_middle[x];
        win[2][2]     = px;
        row_upper[x]  = row_middle[x];
        row_middle[x] = px;
        in_col        = (x + 1 >= w) ? 0 : x + 1;
    endfunction

    // win[row][col]: row 0 above, col 0 left
    function automatic out_beat_t judge_center(input int unsigned w, input int unsigned h);
        out_beat_t beat;
        logic      inner;
        logic      hit;
        inner = out_row >= 1 && out_row + 1 < h && out_col >= 1 && out_col + 1 < w;
        hit = inner && win[1][1] == PIX_ONE && (
            (win[0][1] == PIX_ZERO && win[1][2] == PIX_ZERO &&
             win[0][2] == PIX_ONE  && win[1][0] == PIX_ONE) ||
            (win[0][1] == PIX_ZERO && win[1][2] == PIX_ONE &&
             win[0][2] == PIX_ONE  && win[2][2] == PIX_ZERO) ||
            (win[2][1] == PIX_ZERO && win[1][2] == PIX_ONE &&
             win[2][2] == PIX_ONE  && win[2][0] == PIX_ZERO) ||
            (win[2][1] == PIX_ZERO && win[1][0] == PIX_ONE &&
             win[2][0] == PIX_ONE  && win[0][0] == PIX_ZERO));
        if (hit)
            cleared_count++;
        beat.pixel = hit ? PIX_ZERO : win[1][1];
        beat.last  = (out_row + 1 >= h) && (out_col + 1 >= w);
        if (out_col + 1 >= w)
        begin
            out_col = 0;
            out_row = (out_row + 1 >= h) ? 0 : out_row + 1;
        end
        else
            out_col++;
        return beat;
    endfunction

    function automatic void take_input_beat(input logic drain, input logic [PIX_W-1:0] px);
        int unsigned w;
        int unsigned h;
        int unsigned lag;
        w   = clamp_size(width_reg, MAX_WIDTH);
        h   = clamp_size(height_reg, MAX_HEIGHT);
        lag = w + 1;
        if (held > lag)
            held = lag;
        if (!drain)
        begin
            shift_window(px, w);
            if (held < lag)
                held++;
            else
                expected_pixels.push_back(judge_center(w, h));
        end
        else if (held != 0)
        begin
            shift_window(PIX_ZERO, w);
            held--;
            expected_pixels.push_back(judge_center(w, h));
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_beat_t want;
        if (!rst_n)
        begin
            foreach (row_upper[i])
            begin
                row_upper[i]  = PIX_ZERO;
                row_middle[i] = PIX_ZERO;
            end
            width_reg  = FRAME_WIDTH_RST;
            height_reg = FRAME_HEIGHT_RST;
            restart_frame();
            expected_pixels.delete();
            error_count   = 0;
            pending_beats = 0;
            result_count  = 0;
            cleared_count = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                result_count++;
                if (expected_pixels.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected output beat pixel %0d last %0b",
                             $time, m_axis_tdata, m_axis_tlast);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (m_axis_tdata !== want.pixel)
                    begin
                        error_count++;
                        $display("%0t: pixel_out expected %0d, got %0d",
                                 $time, want.pixel, m_axis_tdata);
                    end
                    if (m_axis_tlast !== want.last)
                    begin
                        error_count++;
                        $display("%0t: last_of_frame expected %0b, got %0b",
                                 $time, want.last, m_axis_tlast);
                    end
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == REG_FRAME_WIDTH)
                    width_reg = cfg_data;
                else if (cfg_index == REG_FRAME_HEIGHT)
                    height_reg = cfg_data;
                restart_frame();
            end
            if (s_axis_tvalid && s_axis_tready)
                take_input_beat(s_axis_tuser, s_axis_tdata);
            pending_beats = expected_pixels.size();
        end
    end

endmodule

// ===== bench/binary_corner_pixel_removal_tb.sv =====
// testbench top for binary corner pixel removal: stimulus, idling and verdict
module binary_corner_pixel_removal_tb;
    import bcpr_pkg::*;

    localparam int   MAX_W          = 1024;
    localparam int   MAX_H          = 1024;
    localparam logic FUNC_PUSH      = 1'b0;
    localparam logic FUNC_DRAIN     = 1'b1;
    localparam int   PIXEL_TARGET   = 650;
    localparam int   RESET_RUN      = 40;
    localparam int   SETTLE_CYCLES  = 8;
    localparam int   HOLD_CYCLES    = 300;
    localparam int   PRESSURE_PHASE = 4;
    localparam int   IDLE_NONE      = 0;
    localparam int   IDLE_SOURCE    = 1;
    localparam int   IDLE_SINK      = 2;
    localparam int   IDLE_BOTH      = 3;

    logic             clk           = 1'b0;
    logic             rst_n         = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [PIX_W-1:0] s_axis_tdata  = '0;   // [7:0] pixel_in
    logic             s_axis_tuser  = 1'b0; // [0] func
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [PIX_W-1:0] m_axis_tdata;         // [7:0] pixel_out
    logic             m_axis_tlast;
    logic             cfg_we        = 1'b0;
    logic [IDX_W-1:0] cfg_index     = REG_FRAME_WIDTH;
    logic [CFG_W-1:0] cfg_data      = '0;

    int   error_count;
    int   pending_beats;
    int   result_count;
    int   cleared_count;
    int   src_idle_pct   = 0;
    int   sink_stall_pct = 0;
    int   phase_no       = 0;
    int   pixels_sent    = 0;
    int   drains_sent    = 0;
    logic pressure_go    = 1'b0;
    logic rx_hold        = 1'b0;

    logic [PIX_W-1:0] corner_frames [18] = '{
        8'd0,   8'd0, 8'd1,  8'd1, 8'd1, 8'd0,  8'd0, 8'd0, 8'd2,
        8'd255, 8'd1, 8'd0,  8'd0, 8'd1, 8'd1,  8'd0, 8'd0, 8'd1
    };

    binary_corner_pixel_removal #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    corner_removal_checker #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .error_count   (error_count),
        .pending_beats (pending_beats),
        .result_count  (result_count),
        .cleared_count (cleared_count)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= !rx_hold && ($urandom_range(99) >= sink_stall_pct);
    end

    // long receiver hold while the source keeps offering beats
    initial
    begin
        wait (pressure_go);
        repeat (10) @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    function automatic logic [PIX_W-1:0] random_pixel(input int unsigned one_pct);
        if ($urandom_range(99) < 15)
            return PIX_W'($urandom_range(0, 255));
        return ($urandom_range(99) < one_pct) ? PIX_ONE : PIX_ZERO;
    endfunction

    task automatic set_idling(input int mode);
        case (mode)
            IDLE_SOURCE:
            begin
                src_idle_pct   = 77;
                sink_stall_pct = 0;
            end
            IDLE_SINK:
            begin
                src_idle_pct   = 0;
                sink_stall_pct = 77;
            end
            IDLE_BOTH:
            begin
                src_idle_pct   = 26;
                sink_stall_pct = 26;
            end
            default:
            begin
                src_idle_pct   = 0;
                sink_stall_pct = 0;
            end
        endcase
    endtask

    task automatic send_beat(input logic func, input logic [PIX_W-1:0] pixel);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= pixel;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (func == FUNC_PUSH)
            pixels_sent++;
        else
            drains_sent++;
    endtask

    task automatic write_frame_size(input logic [CFG_W-1:0] w_code,
                                    input logic [CFG_W-1:0] h_code);
        s_axis_tvalid <= 1'b0;
        while (pending_beats != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_FRAME_WIDTH;
        cfg_data  <= w_code;
        @(posedge clk);
        cfg_index <= REG_FRAME_HEIGHT;
        cfg_data  <= h_code;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] w_code, input logic [CFG_W-1:0] h_code);
        int unsigned w;
        int unsigned h;
        int unsigned pixels;
        int unsigned flush;
        int unsigned one_pct;
        int unsigned i;
        int          room;
        w = (w_code == '0) ? 1 : ((w_code > MAX_W) ? MAX_W : w_code);
        h = (h_code == '0) ? 1 : ((h_code > MAX_H) ? MAX_H : h_code);
        write_frame_size(w_code, h_code);
        set_idling(phase_no % 4);
        one_pct = $urandom_range(25, 75);
        // wide rows only get a short run
        if (w > 64)
        begin
            pixels = $urandom_range(10, 40);
            flush  = pixels + $urandom_range(0, 3);
        end
        else
        begin
            pixels = w * h * $urandom_range(1, 3);
            if (pixels > 160)
                pixels = $urandom_range(24, 160);
            flush = ($urandom_range(3) == 0) ? $urandom_range(0, w + 3) : w + 1;
        end
        if (phase_no == PRESSURE_PHASE)
        begin
            if (pixels < 120)
                pixels = 120;
            pressure_go = 1'b1;
        end
        room = PIXEL_TARGET - pixels_sent - drains_sent;
        if ((phase_no != PRESSURE_PHASE) && (room > 0) && (int'(pixels) > room))
            pixels = unsigned'(room);
        for (i = 0; i < pixels; i++)
        begin
            if ($urandom_range(99) < 3)
                send_beat(FUNC_DRAIN, PIX_W'($urandom_range(0, 255)));
            send_beat(FUNC_PUSH, random_pixel(one_pct));
        end
        for (i = 0; i < flush; i++)
            send_beat(FUNC_DRAIN, PIX_W'($urandom_range(0, 255)));
        phase_no++;
    endtask

    initial
    begin
        int               i;
        int               wait_cycles;
        logic [CFG_W-1:0] w_code;
        logic [CFG_W-1:0] h_code;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset frame size: a short run inside the first row, nothing comes out
        set_idling(IDLE_NONE);
        for (i = 0; i < RESET_RUN; i++)
            send_beat(FUNC_PUSH, random_pixel(50));
        phase_no++;

        // 3x3 frames with a cleared corner each, drain with nothing held first
        write_frame_size(11'd3, 11'd3);
        set_idling(phase_no % 4);
        send_beat(FUNC_DRAIN, 8'hFF);
        foreach (corner_frames[k])
            send_beat(FUNC_PUSH, corner_frames[k]);
        repeat (4) send_beat(FUNC_DRAIN, PIX_ZERO);
        phase_no++;

        while (pixels_sent + drains_sent < PIXEL_TARGET)
        begin
            case (phase_no)
                2:
                begin
                    w_code = '0;
                    h_code = '0;
                end
                3:
                begin
                    w_code = 11'd2047;
                    h_code = 11'd2;
                end
                5:
                begin
                    w_code = 11'd1024;
                    h_code = 11'd2047;
                end
                6:
                begin
                    w_code = 11'd3;
                    h_code = 11'd1024;
                end
                7:
                begin
                    w_code = 11'd1;
                    h_code = 11'd1;
                end
                default:
                begin
                    w_code = ($urandom_range(7) == 0) ? CFG_W'($urandom_range(13, 40))
                                                       : CFG_W'($urandom_range(1, 12));
                    h_code = CFG_W'($urandom_range(1, 9));
                end
            endcase
            run_phase(w_code, h_code);
        end

        s_axis_tvalid <= 1'b0;
        wait_cycles = 0;
        while (pending_beats != 0 && wait_cycles < 20000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (2 * SETTLE_CYCLES) @(posedge clk);
        if (pending_beats != 0)
            $display("%0t: %0d expected output beats never arrived", $time, pending_beats);
        $display("run: %0d pixels and %0d drain beats over %0d frame settings",
                 pixels_sent, drains_sent, phase_no);
        $display("run: %0d output beats checked, %0d corner pixels cleared",
                 result_count, cleared_count);
        if (error_count == 0 && pending_beats == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== files.f =====
sv/bcpr_pkg.sv
sv/bcpr_ram.sv
sv/bcpr_out_fifo.sv
sv/binary_corner_pixel_removal.sv
bench/corner_removal_checker.sv
bench/binary_corner_pixel_removal_tb.sv
